>>> rtl/bpc_pkg.sv
// Shared types, codes and constants of the button press classifier.
// Used by the channel interfaces, the front and back modules and the top level.
package bpc_pkg;

  localparam int unsigned PIN_COUNT   = 16;
  localparam int unsigned PIN_IDX_W   = (PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1;
  localparam int unsigned PIN_W       = 4;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned CFG_W       = 16;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd50;
  localparam logic [CFG_W-1:0] LONG_RESET     = 16'd1000;
  localparam logic [CFG_W-1:0] WINDOW_RESET   = 16'd300;

  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW   = 2'd2;

  localparam logic [1:0] OP_EDGE  = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SIMPLE = 2'd1,
    EV_LONG   = 2'd2,
    EV_DOUBLE = 2'd3
  } ev_t;

  typedef enum logic [1:0] {
    CMD_NOP   = 2'd0,
    CMD_EDGE  = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_EDGE_DIFF,
    BK_EDGE_APPLY,
    BK_TICK,
    BK_EMIT
  } bk_state_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [PIN_W-1:0]  pin;
    logic              level;
    logic [TIME_W-1:0] now_ms;
  } qent_t;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_ms;
    logic [CFG_W-1:0] long_press_ms;
    logic [CFG_W-1:0] double_window_ms;
  } cfg_t;

  function automatic logic [PIN_IDX_W-1:0] pin_to_idx(input logic [PIN_W-1:0] p);
    return PIN_IDX_W'(p);
  endfunction

endpackage

>>> rtl/bpc_if.sv
// Valid/ready channel interfaces: input items, result words and config writes.
// Depends on bpc_pkg for field widths.
interface bpc_in_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 operation;
  logic [bpc_pkg::PIN_W-1:0]  pin;
  logic                       level;
  logic [bpc_pkg::TIME_W-1:0] now_ms;
  modport source(output valid, operation, pin, level, now_ms, input ready);
  modport sink(input valid, operation, pin, level, now_ms, output ready);
endinterface

interface bpc_out_if;
  logic                       valid;
  logic                       ready;
  logic [bpc_pkg::PIN_W-1:0]  button;
  logic [1:0]                 event_kind;
  logic [bpc_pkg::TIME_W-1:0] time_value;
  logic                       press_open;
  logic                       edge_accepted;
  modport source(output valid, button, event_kind, time_value, press_open, edge_accepted,
                 input ready);
  modport sink(input valid, button, event_kind, time_value, press_open, edge_accepted,
               output ready);
endinterface

interface bpc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bpc_pkg::CFG_IDX_W-1:0] index;
  logic [bpc_pkg::CFG_W-1:0]     data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

>>> rtl/bpc_front.sv
// Front end: accepts input words, classifies them into commands and queues them.
// Depends on bpc_pkg and bpc_in_if.
module bpc_front (
  input  logic            clk,
  input  logic            rst_n,
  bpc_in_if.sink          in_ch,
  output logic            q_valid,
  output bpc_pkg::qent_t  q_ent,
  input  logic            q_pop
);

  bpc_pkg::qent_t                  mem_r [bpc_pkg::QUEUE_DEPTH];
  logic [bpc_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [bpc_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [bpc_pkg::QCNT_W-1:0]      count_r, count_nxt;
  logic                            push;
  logic                            pop;
  bpc_pkg::qent_t                  cls;

  assign in_ch.ready = (count_r != bpc_pkg::QCNT_W'(bpc_pkg::QUEUE_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (count_r != '0);
  assign pop         = q_pop && q_valid;
  assign q_ent       = mem_r[rd_ptr_r];

  // classify: out-of-range edges and unknown operations change nothing
  always_comb begin
    cls.pin    = in_ch.pin;
    cls.level  = in_ch.level;
    cls.now_ms = in_ch.now_ms;
    case (in_ch.operation)
      bpc_pkg::OP_EDGE: begin
        if (32'(in_ch.pin) >= bpc_pkg::PIN_COUNT) cls.cmd = bpc_pkg::CMD_NOP;
        else cls.cmd = bpc_pkg::CMD_EDGE;
      end
      bpc_pkg::OP_TICK:  cls.cmd = bpc_pkg::CMD_TICK;
      bpc_pkg::OP_CLEAR: cls.cmd = bpc_pkg::CMD_CLEAR;
      default:           cls.cmd = bpc_pkg::CMD_NOP;
    endcase
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      if (32'(wr_ptr_r) == bpc_pkg::QUEUE_DEPTH - 1) wr_ptr_nxt = '0;
      else wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop) begin
      if (32'(rd_ptr_r) == bpc_pkg::QUEUE_DEPTH - 1) rd_ptr_nxt = '0;
      else rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= cls;
  end

endmodule

>>> rtl/bpc_back.sv
// Back end: executes queued commands against the per-pin tables and event record,
// and holds each result word in an output register. Depends on bpc_pkg and bpc_out_if.
module bpc_back (
  input  logic            clk,
  input  logic            rst_n,
  input  bpc_pkg::cfg_t   cfg,
  input  logic            q_valid,
  input  bpc_pkg::qent_t  q_ent,
  output logic            q_pop,
  bpc_out_if.source       out_ch
);

  localparam int unsigned TW = bpc_pkg::TIME_W;
  localparam int unsigned IW = bpc_pkg::PIN_IDX_W;
  localparam int unsigned PC = bpc_pkg::PIN_COUNT;

  bpc_pkg::bk_state_t          state_r, state_nxt;
  bpc_pkg::qent_t              item_r, item_nxt;
  logic [TW-1:0]               dt_edge_r, dt_edge_nxt;
  logic [TW-1:0]               len_r, len_nxt;
  logic [TW-1:0]               dt_first_r, dt_first_nxt;
  logic [IW-1:0]               scan_r, scan_nxt;
  logic                        acc_r, acc_nxt;
  logic [bpc_pkg::PIN_W-1:0]   button_r, button_nxt;
  bpc_pkg::ev_t                event_r, event_nxt;
  logic [TW-1:0]               sod_r, sod_nxt;
  logic                        pressing_r, pressing_nxt;
  logic [PC-1:0]               le_vld_r, le_vld_nxt;
  logic [PC-1:0]               fr_vld_r, fr_vld_nxt;
  logic [PC-1:0]               await_r, await_nxt;
  logic [TW-1:0]               last_edge_r [PC];
  logic [TW-1:0]               first_rel_r [PC];
  logic                        le_we, fr_we;
  logic [IW-1:0]               item_idx, rd_idx;
  logic [TW-1:0]               le_rd, fr_rd;
  logic                        deb_ok, long_hit, dbl_hit, expire, last_scan, load_out;
  logic                        ov_r, ov_nxt;
  logic [bpc_pkg::PIN_W-1:0]   obutton_r;
  logic [1:0]                  okind_r;
  logic [TW-1:0]               otime_r;
  logic                        oopen_r, oacc_r;

  assign item_idx  = bpc_pkg::pin_to_idx(item_r.pin);
  assign rd_idx    = (state_r == bpc_pkg::BK_TICK) ? scan_r : item_idx;
  assign le_rd     = le_vld_r[rd_idx] ? last_edge_r[rd_idx] : '0;
  assign fr_rd     = fr_vld_r[rd_idx] ? first_rel_r[rd_idx] : '0;
  assign deb_ok    = dt_edge_r >= TW'(cfg.debounce_ms);
  assign long_hit  = len_r >= TW'(cfg.long_press_ms);
  assign dbl_hit   = await_r[item_idx] && (dt_first_r <= TW'(cfg.double_window_ms));
  assign expire    = await_r[scan_r] && ((item_r.now_ms - fr_rd) >= TW'(cfg.double_window_ms));
  assign last_scan = (scan_r == IW'(PC - 1));
  assign load_out  = (state_r == bpc_pkg::BK_EMIT) && (!ov_r || out_ch.ready);
  assign q_pop     = (state_r == bpc_pkg::BK_IDLE) && q_valid;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bpc_pkg::BK_IDLE: begin
        if (q_valid) begin
          case (q_ent.cmd)
            bpc_pkg::CMD_EDGE: state_nxt = bpc_pkg::BK_EDGE_DIFF;
            bpc_pkg::CMD_TICK: state_nxt = bpc_pkg::BK_TICK;
            default:           state_nxt = bpc_pkg::BK_EMIT;
          endcase
        end
      end
      bpc_pkg::BK_EDGE_DIFF:  state_nxt = bpc_pkg::BK_EDGE_APPLY;
      bpc_pkg::BK_EDGE_APPLY: state_nxt = bpc_pkg::BK_EMIT;
      bpc_pkg::BK_TICK: begin
        if (last_scan) state_nxt = bpc_pkg::BK_EMIT;
      end
      bpc_pkg::BK_EMIT: begin
        if (load_out) state_nxt = bpc_pkg::BK_IDLE;
      end
      default: state_nxt = bpc_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    item_nxt     = item_r;
    dt_edge_nxt  = dt_edge_r;
    len_nxt      = len_r;
    dt_first_nxt = dt_first_r;
    scan_nxt     = scan_r;
    acc_nxt      = acc_r;
    button_nxt   = button_r;
    event_nxt    = event_r;
    sod_nxt      = sod_r;
    pressing_nxt = pressing_r;
    le_vld_nxt   = le_vld_r;
    fr_vld_nxt   = fr_vld_r;
    await_nxt    = await_r;
    le_we        = 1'b0;
    fr_we        = 1'b0;
    case (state_r)
      bpc_pkg::BK_IDLE: begin
        if (q_valid) begin
          item_nxt = q_ent;
          acc_nxt  = 1'b0;
          scan_nxt = '0;
          if (q_ent.cmd == bpc_pkg::CMD_CLEAR) begin
            event_nxt    = bpc_pkg::EV_NONE;
            sod_nxt      = '0;
            pressing_nxt = 1'b0;
          end
        end
      end
      bpc_pkg::BK_EDGE_DIFF: begin
        dt_edge_nxt  = item_r.now_ms - le_rd;
        len_nxt      = item_r.now_ms - sod_r;
        dt_first_nxt = item_r.now_ms - fr_rd;
      end
      bpc_pkg::BK_EDGE_APPLY: begin
        if (deb_ok) begin
          acc_nxt              = 1'b1;
          le_we                = 1'b1;
          le_vld_nxt[item_idx] = 1'b1;
          if (!item_r.level) begin
            button_nxt   = item_r.pin;
            sod_nxt      = item_r.now_ms;
            pressing_nxt = 1'b1;
          end else if ((button_r == item_r.pin) && pressing_r) begin
            sod_nxt      = len_r;
            pressing_nxt = 1'b0;
            if (long_hit) begin
              event_nxt           = bpc_pkg::EV_LONG;
              await_nxt[item_idx] = 1'b0;
            end else if (dbl_hit) begin
              event_nxt           = bpc_pkg::EV_DOUBLE;
              await_nxt[item_idx] = 1'b0;
            end else begin
              fr_we                = 1'b1;
              fr_vld_nxt[item_idx] = 1'b1;
              await_nxt[item_idx]  = 1'b1;
              event_nxt            = bpc_pkg::EV_NONE;
            end
          end
        end
      end
      bpc_pkg::BK_TICK: begin
        if (expire) begin
          button_nxt        = bpc_pkg::PIN_W'(scan_r);
          event_nxt         = bpc_pkg::EV_SIMPLE;
          pressing_nxt      = 1'b0;
          sod_nxt           = TW'(1);
          await_nxt[scan_r] = 1'b0;
        end
        if (!last_scan) scan_nxt = scan_r + 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    ov_nxt = ov_r;
    if (load_out) ov_nxt = 1'b1;
    else if (out_ch.ready) ov_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= bpc_pkg::BK_IDLE;
      button_r   <= '0;
      event_r    <= bpc_pkg::EV_NONE;
      sod_r      <= '0;
      pressing_r <= 1'b0;
      le_vld_r   <= '0;
      fr_vld_r   <= '0;
      await_r    <= '0;
      ov_r       <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      button_r   <= button_nxt;
      event_r    <= event_nxt;
      sod_r      <= sod_nxt;
      pressing_r <= pressing_nxt;
      le_vld_r   <= le_vld_nxt;
      fr_vld_r   <= fr_vld_nxt;
      await_r    <= await_nxt;
      ov_r       <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    dt_edge_r  <= dt_edge_nxt;
    len_r      <= len_nxt;
    dt_first_r <= dt_first_nxt;
    scan_r     <= scan_nxt;
    acc_r      <= acc_nxt;
    if (le_we) last_edge_r[item_idx] <= item_r.now_ms;
    if (fr_we) first_rel_r[item_idx] <= item_r.now_ms;
    if (load_out) begin
      obutton_r <= button_r;
      okind_r   <= event_r;
      otime_r   <= sod_r;
      oopen_r   <= pressing_r;
      oacc_r    <= acc_r;
    end
  end

  assign out_ch.valid         = ov_r;
  assign out_ch.button        = obutton_r;
  assign out_ch.event_kind    = okind_r;
  assign out_ch.time_value    = otime_r;
  assign out_ch.press_open    = oopen_r;
  assign out_ch.edge_accepted = oacc_r;

endmodule

>>> rtl/button_press_classifier.sv
// Top level of the button press classifier: config registers, front and back ends.
// Depends on bpc_pkg, the bpc channel interfaces, bpc_front and bpc_back.
//
// Every input word (pin edge, tick scan or clear) yields exactly one result word
// showing the event record after that word. The front end queues up to two words
// ahead of the back end. In the back end an edge passes take, difference, apply
// and emit, a clear or other word take and emit, and a tick take, a scan of each
// pin and emit: the tick walks the per-pin tables one entry a cycle through one
// shared subtract-and-compare. A finished result waits in an output register
// while the next word is taken. Config writes are accepted in any cycle.
module button_press_classifier (
  input  logic      clk,
  input  logic      rst_n,
  bpc_in_if.sink    in_ch,
  bpc_out_if.source out_ch,
  bpc_cfg_if.sink   cfg_ch
);

  bpc_pkg::cfg_t  cfg_r;
  logic           q_valid;
  logic           q_pop;
  bpc_pkg::qent_t q_ent;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms      <= bpc_pkg::DEBOUNCE_RESET;
      cfg_r.long_press_ms    <= bpc_pkg::LONG_RESET;
      cfg_r.double_window_ms <= bpc_pkg::WINDOW_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        bpc_pkg::CFG_DEBOUNCE: cfg_r.debounce_ms      <= cfg_ch.data;
        bpc_pkg::CFG_LONG:     cfg_r.long_press_ms    <= cfg_ch.data;
        bpc_pkg::CFG_WINDOW:   cfg_r.double_window_ms <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  bpc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_ent   (q_ent),
    .q_pop   (q_pop)
  );

  bpc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_valid (q_valid),
    .q_ent   (q_ent),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_pop_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> !q_pop)
    else $error("back end took two words in consecutive cycles");

  a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> q_valid)
    else $error("input stalled with an empty queue");

endmodule
